/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted (active low).
`define CHK_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must hold whenever the trigger is true.
`define CHK_IMPL(lbl, clk, rst_n, trig, cond, msg) \
	`CHK_PROP(lbl, clk, rst_n, (trig) |-> (cond), msg)

`endif

/* rtl/core/pba_pkg.sv */
// ----------------------------------------------------------------------------
// pba_pkg
// Types, constants and helpers for the piece bitmap allocator.
// ----------------------------------------------------------------------------
package pba_pkg;

	localparam int MAX_PIECES = 1024;
	localparam int IDX_W      = 10;
	localparam int CNT_W      = 11;
	localparam int PLEN_W     = 25;
	localparam int FLEN_W     = 40;
	localparam int WORD_W     = 32;
	localparam int BIT_W      = $clog2(WORD_W);
	localparam int ROWS       = MAX_PIECES / WORD_W;
	localparam int ROW_AW     = $clog2(ROWS);
	localparam int ROW_W      = 2 * WORD_W;
	localparam int PROD_W     = CNT_W + PLEN_W;

	localparam logic [1:0] CMD_BUSY  = 2'd0;
	localparam logic [1:0] CMD_DONE  = 2'd1;
	localparam logic [1:0] CMD_QUERY = 2'd2;

	localparam logic [1:0] CFG_PLEN = 2'd0;
	localparam logic [1:0] CFG_FLEN = 2'd1;
	localparam logic [1:0] CFG_PCNT = 2'd2;

	localparam logic [PLEN_W-1:0] PLEN_RST = PLEN_W'(262144);
	localparam logic [FLEN_W-1:0] FLEN_RST = FLEN_W'(262144);
	localparam logic [CNT_W-1:0]  PCNT_RST = CNT_W'(1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RMW,
		ST_SCAN,
		ST_MUL,
		ST_SUB,
		ST_ADD
	} state_t;

	// lowest set bit of a bitmap word
	function automatic logic [BIT_W-1:0] first_set(input logic [WORD_W-1:0] v);
		logic [BIT_W-1:0] pos;
		pos = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (v[i]) pos = BIT_W'(i);
		end
		return pos;
	endfunction

endpackage

/* rtl/core/pba_ram.sv */
// ----------------------------------------------------------------------------
// pba_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pba_ram #(
	parameter int WIDTH = pba_pkg::ROW_W,
	parameter int DEPTH = pba_pkg::ROWS
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/core/piece_bitmap_allocator_unit.sv */
// The scan covers W = ceil(pieces_in_use/32) bitmap words (at most 32); a bad
// index skips the read-modify-write of its row and goes straight to the scan.
// One item at a time: the next word is taken the cycle after the result loads.
// The scan reads one 64-bit done/busy row of the bitmap RAM per cycle; one
// shared multiplier then serves both byte-count products in turn, in ST_MUL then ST_SUB.
// Reset: control registers to defaults, row valid flags cleared, so maps read as empty.
// ----------------------------------------------------------------------------
// piece_bitmap_allocator_unit
// Done/in-progress bitmaps with find-first-free scan and bytes-left count.
// ----------------------------------------------------------------------------
module piece_bitmap_allocator_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [1:0]                   cfg_index,
	input  logic [pba_pkg::FLEN_W-1:0]   cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   cmd,
	input  logic [pba_pkg::IDX_W-1:0]    piece_index,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         piece_have,
	output logic [pba_pkg::IDX_W-1:0]    next_piece,
	output logic                         next_found,
	output logic                         all_complete,
	output logic [pba_pkg::FLEN_W-1:0]   bytes_remaining,
	output logic                         index_error
);

	import pba_pkg::*;

	state_t state_q, state_d;

	logic [PLEN_W-1:0] plen_q;
	logic [FLEN_W-1:0] flen_q;
	logic [CNT_W-1:0]  pcnt_q;

	logic [ROWS-1:0]   row_vld_q;
	logic [CNT_W-1:0]  done_total_q;

	logic [1:0]        cmd_q;
	logic [IDX_W-1:0]  idx_q;
	logic              err_q;
	logic [CNT_W-1:0]  n_q;
	logic [IDX_W-1:0]  nm1_q;
	logic              have_q;
	logic              found_q;
	logic [IDX_W-1:0]  next_q;
	logic              lastdone_q;
	logic              lm_q;
	logic [CNT_W-1:0]  cnt2_q;
	logic [PROD_W-1:0] mul_q;
	logic [FLEN_W-1:0] last_size_q;

	logic [ROW_AW-1:0] rd_addr_q;
	logic              rd_live_q;
	logic              ev_vld_s1;
	logic [ROW_AW-1:0] ev_addr_s1;
	logic              rd_vld_s1;

	logic              out_valid_q;

	// ram ports
	logic              ram_we;
	logic [ROW_AW-1:0] ram_waddr;
	logic [ROW_W-1:0]  ram_wdata;
	logic [ROW_AW-1:0] ram_raddr;
	logic [ROW_W-1:0]  ram_rdata;

	logic              accept;
	logic              slot_free;
	logic [CNT_W-1:0]  n_c;
	logic              err_c;
	logic [WORD_W-1:0] row_done;
	logic [WORD_W-1:0] row_busy;
	logic [WORD_W-1:0] done_new;
	logic [WORD_W-1:0] busy_new;
	logic [BIT_W-1:0]  bit_sel;
	logic              newly_done;
	logic [ROW_AW-1:0] last_word;
	logic [WORD_W-1:0] scan_mask;
	logic [WORD_W-1:0] free_bits;
	logic [CNT_W-1:0]  mul_in;
	logic [PROD_W-1:0] prod;
	logic [CNT_W-1:0]  missing;
	logic              lm_c;
	logic [FLEN_W-1:0] others;
	logic [FLEN_W:0]   sum;
	logic [FLEN_W-1:0] bytes_c;

	pba_ram #(
		.WIDTH(ROW_W),
		.DEPTH(ROWS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// pieces in use, held to 1..MAX_PIECES
	always_comb begin
		if (pcnt_q == '0) n_c = CNT_W'(1);
		else if (pcnt_q > CNT_W'(MAX_PIECES)) n_c = CNT_W'(MAX_PIECES);
		else n_c = pcnt_q;
	end
	assign err_c = {1'b0, piece_index} >= n_c;

	// row contents as read; a row never written reads as empty
	assign row_done = rd_vld_s1 ? ram_rdata[WORD_W-1:0] : '0;
	assign row_busy = rd_vld_s1 ? ram_rdata[ROW_W-1:WORD_W] : '0;
	assign bit_sel  = idx_q[BIT_W-1:0];

	always_comb begin
		done_new   = row_done;
		busy_new   = row_busy;
		newly_done = 1'b0;
		case (cmd_q)
			CMD_BUSY: begin
				busy_new[bit_sel] = 1'b1;
			end
			CMD_DONE: begin
				done_new[bit_sel] = 1'b1;
				busy_new[bit_sel] = 1'b0;
				newly_done        = !row_done[bit_sel];
			end
			default: begin
			end
		endcase
	end

	assign last_word = nm1_q[IDX_W-1:BIT_W];
	// keep only pieces in use in the last word
	assign scan_mask = (ev_addr_s1 == last_word) ? ({WORD_W{1'b1}} >> ~nm1_q[BIT_W-1:0])
	                                             : {WORD_W{1'b1}};
	assign free_bits = ~row_done & ~row_busy & scan_mask;

	// shared multiplier: other pieces' total, then missing full pieces
	assign mul_in  = (state_q == ST_MUL) ? {1'b0, nm1_q} : cnt2_q;
	assign prod    = mul_in * plen_q;
	assign missing = (done_total_q <= n_q) ? (n_q - done_total_q) : '0;
	assign lm_c    = !lastdone_q && (missing != '0);
	assign others  = FLEN_W'(mul_q);
	assign sum     = {1'b0, (lm_q ? last_size_q : '0)} + (FLEN_W + 1)'(mul_q);
	assign bytes_c = sum[FLEN_W] ? {FLEN_W{1'b1}} : sum[FLEN_W-1:0];

	// next state and ram control
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = idx_q[IDX_W-1:BIT_W];
		ram_wdata = {busy_new, done_new};
		ram_raddr = rd_addr_q;
		case (state_q)
			ST_IDLE: begin
				ram_raddr = piece_index[IDX_W-1:BIT_W];
				if (accept) state_d = err_c ? ST_SCAN : ST_RMW;
			end
			ST_RMW: begin
				ram_we  = 1'b1;
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (ev_vld_s1 && ev_addr_s1 == last_word) state_d = ST_MUL;
			end
			ST_MUL: begin
				state_d = ST_SUB;
			end
			ST_SUB: begin
				state_d = ST_ADD;
			end
			ST_ADD: begin
				if (slot_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q       <= PLEN_RST;
			flen_q       <= FLEN_RST;
			pcnt_q       <= PCNT_RST;
			row_vld_q    <= '0;
			done_total_q <= '0;
			rd_live_q    <= 1'b0;
			ev_vld_s1    <= 1'b0;
			rd_vld_s1    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			rd_vld_s1 <= row_vld_q[ram_raddr];
			ev_vld_s1 <= (state_q == ST_SCAN) && rd_live_q;
			if (cfg_valid) begin
				case (cfg_index)
					CFG_PLEN: plen_q <= cfg_data[PLEN_W-1:0];
					CFG_FLEN: flen_q <= cfg_data;
					CFG_PCNT: begin
						// new file: drop both maps
						pcnt_q       <= cfg_data[CNT_W-1:0];
						row_vld_q    <= '0;
						done_total_q <= '0;
					end
					default: begin
					end
				endcase
			end
			if (accept) rd_live_q <= 1'b1;
			if (state_q == ST_SCAN && rd_live_q && rd_addr_q == last_word) rd_live_q <= 1'b0;
			if (ram_we) begin
				row_vld_q[ram_waddr] <= 1'b1;
				if (newly_done) done_total_q <= done_total_q + CNT_W'(1);
			end
			if (state_q == ST_ADD && slot_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q     <= cmd;
			idx_q     <= piece_index;
			err_q     <= err_c;
			n_q       <= n_c;
			nm1_q     <= IDX_W'(n_c - CNT_W'(1));
			have_q    <= 1'b0;
			found_q   <= 1'b0;
			next_q    <= '0;
			rd_addr_q <= '0;
		end
		if (state_q == ST_RMW) have_q <= done_new[bit_sel];
		if (state_q == ST_SCAN) begin
			if (rd_live_q) begin
				ev_addr_s1 <= rd_addr_q;
				rd_addr_q  <= rd_addr_q + ROW_AW'(1);
			end
			if (ev_vld_s1) begin
				if (!found_q && (free_bits != '0)) begin
					found_q <= 1'b1;
					next_q  <= {ev_addr_s1, first_set(free_bits)};
				end
				if (ev_addr_s1 == last_word) lastdone_q <= row_done[nm1_q[BIT_W-1:0]];
			end
		end
		if (state_q == ST_MUL) begin
			mul_q  <= prod;
			lm_q   <= lm_c;
			cnt2_q <= missing - CNT_W'(lm_c);
		end
		if (state_q == ST_SUB) begin
			last_size_q <= (flen_q > others) ? (flen_q - others) : '0;
			mul_q       <= prod;
		end
		if (state_q == ST_ADD && slot_free) begin
			piece_have      <= have_q;
			next_piece      <= next_q;
			next_found      <= found_q;
			all_complete    <= (done_total_q == n_q);
			bytes_remaining <= bytes_c;
			index_error     <= err_q;
		end
	end

endmodule

/* rtl/core/pba_checker.sv */
// ----------------------------------------------------------------------------
// pba_checker
// Port-level assertions for the piece bitmap allocator, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pba_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       cfg_valid,
	input logic                       cfg_ready,
	input logic [1:0]                 cfg_index,
	input logic [pba_pkg::FLEN_W-1:0] cfg_data,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic [1:0]                 cmd,
	input logic [pba_pkg::IDX_W-1:0]  piece_index,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic                       piece_have,
	input logic [pba_pkg::IDX_W-1:0]  next_piece,
	input logic                       next_found,
	input logic                       all_complete,
	input logic [pba_pkg::FLEN_W-1:0] bytes_remaining,
	input logic                       index_error
);

	// a stalled result word holds
	`CHK_PROP(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(bytes_remaining) && $stable(next_piece), "result word changed while stalled")
	// one word in flight: busy straight after accept
	`CHK_PROP(a_busy_after_accept, clk, arst_n, in_valid && in_ready |=> !in_ready, "input taken again while busy")
	`CHK_IMPL(a_err_no_have, clk, arst_n, out_valid && index_error, !piece_have, "piece_have set on bad index")
	`CHK_IMPL(a_none_zero, clk, arst_n, out_valid && !next_found, next_piece == '0, "next_piece nonzero with no free piece")
	`CHK_IMPL(a_done_no_bytes, clk, arst_n, out_valid && all_complete, bytes_remaining == '0, "bytes left when all complete")

endmodule

bind piece_bitmap_allocator_unit pba_checker u_pba_checker (.*);
